@@ rtl/assert_macros.svh @@
// assertion helper macros for the boost pressure controller
// used by the top level only; define ASSERT_OFF to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/bppc_pkg.sv @@
// shared types and constants of the boost pressure pid controller
// no dependencies
package bppc_pkg;

	localparam int ATM_PRESSURE = 101325;
	localparam int HYSTERESIS   = 5000;
	localparam int DUTY_SCALE   = 100000;
	localparam int DUTY_LIMIT   = 100000000;
	localparam int GAIN_SCALE   = 1000;
	localparam int DUTY_MAX     = 999;

	localparam int PRES_W  = 19;
	localparam int DT_W    = 20;
	localparam int BOOST_W = 20;
	localparam int ERR_W   = 21;
	localparam int DERR_W  = 22;
	localparam int INTEG_W = 64;
	localparam int DUTY_W  = 10;
	localparam int GAIN_W  = 16;
	localparam int KSCL_W  = 26;
	localparam int OFFS_W  = 27;
	localparam int ACC_W   = 52;
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 27;
	localparam int MUL_P_W = 60;
	localparam int DIVN_W  = 84;
	localparam int DIV_RB  = 4;
	localparam int CFG_W   = 19;
	localparam int IDX_W   = 3;

	localparam logic [49:0] ITERM_CAP = 50'h2_0000_0000_0000;

	localparam logic [IDX_W-1:0] REG_TARGET   = 3'd0;
	localparam logic [IDX_W-1:0] REG_ENERGISE = 3'd1;
	localparam logic [IDX_W-1:0] REG_PID_START = 3'd2;
	localparam logic [IDX_W-1:0] REG_PROP     = 3'd3;
	localparam logic [IDX_W-1:0] REG_INTEG    = 3'd4;
	localparam logic [IDX_W-1:0] REG_DERIV    = 3'd5;
	localparam logic [IDX_W-1:0] REG_CEILING  = 3'd6;
	localparam logic [IDX_W-1:0] REG_OFFSET   = 3'd7;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_EVAL,
		OP_MUL_LEAK_LO,
		OP_MUL_LEAK_HI,
		OP_DIV_LEAK,
		OP_WAIT,
		OP_LEAK,
		OP_ADD_EDT,
		OP_MUL_INT_LO,
		OP_MUL_INT_HI,
		OP_ITERM,
		OP_ACC_P,
		OP_ACC_D,
		OP_DIV_DUTY,
		OP_DUTY,
		OP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   load;
	} cmd_t;

	typedef struct packed {
		logic pid_branch;
		logic div_busy;
		logic duty_div;
	} status_t;

	typedef struct packed {
		logic [PRES_W-1:0] target;
		logic [PRES_W-1:0] energise;
		logic [PRES_W-1:0] pid_start;
		logic [GAIN_W-1:0] ki;
		logic [KSCL_W-1:0] kp_k;
		logic [KSCL_W-1:0] kd_k;
		logic [DUTY_W-1:0] ceiling;
		logic [OFFS_W-1:0] offset_k;
	} cfg_t;

	typedef struct packed {
		logic [DUTY_W-1:0]         duty;
		logic                      energised;
		logic                      regulating;
		logic signed [BOOST_W-1:0] boost;
		logic                      limit;
	} res_t;

endpackage

@@ rtl/bppc_div.sv @@
// radix-16 restoring divider, quotient bits shift in at the bottom
// depends on bppc_pkg
module bppc_div #(
	parameter int unsigned N  = 84,
	parameter int unsigned DW = 26
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [N-1:0]  dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic [N-1:0]  quotient
);

	localparam int unsigned RB   = bppc_pkg::DIV_RB;
	localparam int unsigned ITER = N / RB;
	localparam int unsigned CW   = $clog2(ITER + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q, rem_n, div_q;
	logic [N-1:0]  quo_q, quo_n;

	always_comb begin
		logic [DW:0] t;
		rem_n = rem_q;
		quo_n = quo_q;
		for (int i = 0; i < RB; i++) begin
			t = {rem_n, quo_n[N-1]};
			quo_n = {quo_n[N-2:0], 1'b0};
			if (t >= {1'b0, div_q}) begin
				t = t - {1'b0, div_q};
				quo_n[0] = 1'b1;
			end
			rem_n = t[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(ITER);
		end else if (busy_q) begin
			busy_q <= (cnt_q != CW'(1));
			cnt_q  <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

@@ rtl/bppc_dp.sv @@
// datapath: loop state, shared multiplier, accumulator and divider
// depends on bppc_pkg and bppc_div
module bppc_dp #(
	parameter int unsigned DIV_D     = 1000000,
	parameter int unsigned DIVISOR_W = 26
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bppc_pkg::cmd_t                    cmd,
	input  bppc_pkg::cfg_t                    cfg,
	input  logic [bppc_pkg::PRES_W-1:0]       pressure_abs,
	input  logic [bppc_pkg::DT_W-1:0]         elapsed_us,
	output bppc_pkg::status_t                 status,
	output bppc_pkg::res_t                    res
);

	localparam int N = bppc_pkg::DIVN_W;

	logic [bppc_pkg::PRES_W-1:0]         pres_q;
	logic [bppc_pkg::DT_W-1:0]           dt_q;
	logic signed [bppc_pkg::BOOST_W-1:0] boost_q;
	logic signed [bppc_pkg::ERR_W-1:0]   e_q, last_q;
	logic                                on_q, run_q, regl_q, lim_q;
	logic signed [bppc_pkg::INTEG_W-1:0] integ_q;
	logic signed [bppc_pkg::MUL_P_W-1:0] prod_q;
	logic [51:0]                         part_q;
	logic signed [bppc_pkg::ACC_W-1:0]   acc_q;
	logic [bppc_pkg::DUTY_W-1:0]         duty_q;

	logic signed [bppc_pkg::ERR_W-1:0]   boost_w, e_c;
	logic signed [21:0]                  b22, on_thr, off_thr;
	logic                                new_on, pid_c, lim_c;
	logic signed [bppc_pkg::DERR_W-1:0]  de_c;
	logic [62:0]                         integ_mag;
	logic [63:0]                         integ_neg;
	logic signed [bppc_pkg::MUL_A_W-1:0] mul_a;
	logic signed [bppc_pkg::MUL_B_W-1:0] mul_b;
	logic                                div_start, div_busy, duty_div;
	logic [N-1:0]                        div_num, quot;
	logic [DIVISOR_W-1:0]                div_den;
	logic [N:0]                          diff, absd;
	logic                                q_gt, leak_neg;
	logic [62:0]                         magn;
	logic signed [63:0]                  leak_c, sadd_c;
	logic signed [64:0]                  ssum, edt;
	logic [64:0]                         pr;
	logic                                icap;
	logic [49:0]                         pc;
	logic signed [bppc_pkg::ACC_W-1:0]   iterm;
	logic [bppc_pkg::DUTY_W-1:0]         qd;

	// boost, hysteresis and branch choice
	assign boost_w = $signed({2'b00, pres_q}) - $signed(21'(bppc_pkg::ATM_PRESSURE));
	assign b22     = {boost_w[20], boost_w};
	assign on_thr  = $signed({3'b000, cfg.energise});
	assign off_thr = on_thr - $signed(22'(bppc_pkg::HYSTERESIS));
	assign new_on  = on_q ? !(b22 < off_thr) : (b22 > on_thr);
	assign pid_c   = new_on && (b22 >= $signed({3'b000, cfg.pid_start}));
	assign e_c     = boost_w - $signed({2'b00, cfg.target});
	assign lim_c   = boost_w >= $signed({2'b00, cfg.target});
	assign de_c    = {e_q[20], e_q} - {last_q[20], last_q};

	assign integ_neg = -integ_q;
	assign integ_mag = integ_q[63] ? integ_neg[62:0] : integ_q[62:0];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			bppc_pkg::OP_MUL_LEAK_LO: begin
				mul_a = {1'b0, integ_mag[31:0]};
				mul_b = {7'b0, dt_q};
			end
			bppc_pkg::OP_MUL_LEAK_HI: begin
				mul_a = {2'b0, integ_mag[62:32]};
				mul_b = {7'b0, dt_q};
			end
			bppc_pkg::OP_LEAK: begin
				mul_a = {{12{e_q[20]}}, e_q};
				mul_b = {7'b0, dt_q};
			end
			bppc_pkg::OP_MUL_INT_LO: begin
				mul_a = {9'b0, integ_mag[23:0]};
				mul_b = {11'b0, cfg.ki};
			end
			bppc_pkg::OP_MUL_INT_HI: begin
				mul_a = {8'b0, integ_mag[48:24]};
				mul_b = {11'b0, cfg.ki};
			end
			bppc_pkg::OP_ITERM: begin
				mul_a = {{12{e_q[20]}}, e_q};
				mul_b = {1'b0, cfg.kp_k};
			end
			bppc_pkg::OP_ACC_P: begin
				mul_a = {{11{de_c[21]}}, de_c};
				mul_b = {1'b0, cfg.kd_k};
			end
			default: ;
		endcase
	end

	// leak: integrator minus integrator*dt/window, sign flips when the leak overshoots
	assign diff     = {1'b0, quot} - {{(N + 1 - 63){1'b0}}, integ_mag};
	assign absd     = diff[N] ? -diff : diff;
	assign q_gt     = !diff[N] && (diff != '0);
	assign magn     = (|absd[N:63]) ? {63{1'b1}} : absd[62:0];
	assign leak_neg = integ_q[63] ^ q_gt;
	assign leak_c   = leak_neg ? -$signed({1'b0, magn}) : $signed({1'b0, magn});

	// saturating add of e*dt, symmetric limits so the most negative code never appears
	assign edt    = {{24{prod_q[40]}}, prod_q[40:0]};
	assign ssum   = {integ_q[63], integ_q} + edt;
	assign sadd_c = (!ssum[64] && ssum[63]) ? {1'b0, {63{1'b1}}} :
	                (ssum[64] && (!ssum[63] || (ssum[62:0] == '0))) ?
	                {1'b1, {62{1'b0}}, 1'b1} : ssum[63:0];

	// integral term with its magnitude cap
	assign pr    = {prod_q[40:0], 24'b0} + {25'b0, part_q[39:0]};
	assign icap  = ((|integ_mag[62:49]) && (cfg.ki != '0)) || (pr > {15'b0, bppc_pkg::ITERM_CAP});
	assign pc    = icap ? bppc_pkg::ITERM_CAP : pr[49:0];
	assign iterm = integ_q[63] ? -$signed({2'b0, pc}) : $signed({2'b0, pc});

	assign duty_div = !acc_q[51] && (acc_q[50:0] < 51'(bppc_pkg::DUTY_LIMIT));
	assign qd       = quot[bppc_pkg::DUTY_W-1:0];

	assign div_start = (cmd.op == bppc_pkg::OP_DIV_LEAK) ||
	                   ((cmd.op == bppc_pkg::OP_DIV_DUTY) && duty_div);
	assign div_num   = (cmd.op == bppc_pkg::OP_DIV_LEAK) ?
	                   ({1'b0, prod_q[50:0], 32'b0} + {32'b0, part_q}) :
	                   {{(N - 27){1'b0}}, acc_q[26:0]};
	assign div_den   = (cmd.op == bppc_pkg::OP_DIV_LEAK) ? DIVISOR_W'(DIV_D) :
	                   DIVISOR_W'(bppc_pkg::DUTY_SCALE);

	bppc_div #(
		.N  (N),
		.DW (DIVISOR_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q    <= 1'b0;
			run_q   <= 1'b0;
			last_q  <= '0;
			integ_q <= '0;
		end else begin
			unique case (cmd.op)
				bppc_pkg::OP_EVAL: begin
					on_q <= new_on;
					if (pid_c) begin
						run_q <= 1'b1;
						if (!run_q) begin
							last_q  <= '0;
							integ_q <= '0;
						end
					end else begin
						run_q <= 1'b0;
					end
				end
				bppc_pkg::OP_LEAK:     integ_q <= leak_c;
				bppc_pkg::OP_ADD_EDT:  integ_q <= sadd_c;
				bppc_pkg::OP_DIV_DUTY: last_q  <= e_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.load) begin
			pres_q <= pressure_abs;
			dt_q   <= elapsed_us;
		end
		unique case (cmd.op)
			bppc_pkg::OP_EVAL: begin
				boost_q <= boost_w[bppc_pkg::BOOST_W-1:0];
				e_q     <= e_c;
				lim_q   <= lim_c;
				regl_q  <= pid_c;
				// first regulating step sees no elapsed time
				if (pid_c && !run_q)
					dt_q <= '0;
				if (!pid_c)
					duty_q <= new_on ? cfg.ceiling : '0;
			end
			bppc_pkg::OP_MUL_LEAK_HI: part_q <= prod_q[51:0];
			bppc_pkg::OP_MUL_INT_HI:  part_q <= {12'b0, prod_q[39:0]};
			bppc_pkg::OP_ITERM: acc_q <= iterm + $signed({25'b0, cfg.offset_k});
			bppc_pkg::OP_ACC_P: acc_q <= acc_q + prod_q[bppc_pkg::ACC_W-1:0];
			bppc_pkg::OP_ACC_D: acc_q <= acc_q + prod_q[bppc_pkg::ACC_W-1:0];
			bppc_pkg::OP_DIV_DUTY: begin
				if (acc_q[51])
					duty_q <= '0;
				else if (!duty_div)
					duty_q <= cfg.ceiling;
			end
			bppc_pkg::OP_DUTY: duty_q <= (qd > cfg.ceiling) ? cfg.ceiling : qd;
			default: ;
		endcase
	end

	assign status.pid_branch = pid_c;
	assign status.div_busy   = div_busy;
	assign status.duty_div   = duty_div;

	assign res.duty       = duty_q;
	assign res.energised  = on_q;
	assign res.regulating = regl_q;
	assign res.boost      = boost_q;
	assign res.limit      = lim_q;

endmodule

@@ rtl/bppc_ctrl.sv @@
// controller state machine sequencing the datapath one sample at a time
// depends on bppc_pkg
module bppc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               out_free,
	input  bppc_pkg::status_t  status,
	output logic               item_ready,
	output bppc_pkg::cmd_t     cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_EVAL, S_MLL, S_MLH, S_DIVL, S_WAITL, S_LEAK, S_ADDE,
		S_MIL, S_MIH, S_ITERM, S_ACCP, S_ACCD, S_DIVD, S_WAITD, S_DUTY, S_DONE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (item_valid) state_q <= S_EVAL;
				S_EVAL:  state_q <= status.pid_branch ? S_MLL : S_DONE;
				S_MLL:   state_q <= S_MLH;
				S_MLH:   state_q <= S_DIVL;
				S_DIVL:  state_q <= S_WAITL;
				S_WAITL: if (!status.div_busy) state_q <= S_LEAK;
				S_LEAK:  state_q <= S_ADDE;
				S_ADDE:  state_q <= S_MIL;
				S_MIL:   state_q <= S_MIH;
				S_MIH:   state_q <= S_ITERM;
				S_ITERM: state_q <= S_ACCP;
				S_ACCP:  state_q <= S_ACCD;
				S_ACCD:  state_q <= S_DIVD;
				S_DIVD:  state_q <= status.duty_div ? S_WAITD : S_DONE;
				S_WAITD: if (!status.div_busy) state_q <= S_DUTY;
				S_DUTY:  state_q <= S_DONE;
				S_DONE:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.load = (state_q == S_IDLE) && item_valid;
		unique case (state_q)
			S_IDLE:  cmd.op = bppc_pkg::OP_IDLE;
			S_EVAL:  cmd.op = bppc_pkg::OP_EVAL;
			S_MLL:   cmd.op = bppc_pkg::OP_MUL_LEAK_LO;
			S_MLH:   cmd.op = bppc_pkg::OP_MUL_LEAK_HI;
			S_DIVL:  cmd.op = bppc_pkg::OP_DIV_LEAK;
			S_WAITL: cmd.op = bppc_pkg::OP_WAIT;
			S_LEAK:  cmd.op = bppc_pkg::OP_LEAK;
			S_ADDE:  cmd.op = bppc_pkg::OP_ADD_EDT;
			S_MIL:   cmd.op = bppc_pkg::OP_MUL_INT_LO;
			S_MIH:   cmd.op = bppc_pkg::OP_MUL_INT_HI;
			S_ITERM: cmd.op = bppc_pkg::OP_ITERM;
			S_ACCP:  cmd.op = bppc_pkg::OP_ACC_P;
			S_ACCD:  cmd.op = bppc_pkg::OP_ACC_D;
			S_DIVD:  cmd.op = bppc_pkg::OP_DIV_DUTY;
			S_WAITD: cmd.op = bppc_pkg::OP_WAIT;
			S_DUTY:  cmd.op = bppc_pkg::OP_DUTY;
			S_DONE:  cmd.op = bppc_pkg::OP_PUBLISH;
			default: cmd.op = bppc_pkg::OP_IDLE;
		endcase
	end

	assign item_ready = (state_q == S_IDLE);

endmodule

@@ rtl/boost_pressure_pid_controller_core.sv @@
// Boost pressure solenoid controller: one manifold pressure sample in, one duty result out.
// A sample that leaves the solenoid off or pinned at the duty ceiling skips the PID steps;
// a regulating sample uses the shared 4-bit-per-cycle divider for the integrator leak and,
// unless the sum is negative or at full scale, for scaling to tenths of a percent.
// A finished result sits in the output register while the next sample is taken in. The
// integrator window is set by INTEG_WINDOW_MS in milliseconds; zero acts as one.
// depends on bppc_pkg, bppc_ctrl, bppc_dp, bppc_div and assert_macros.svh
`include "assert_macros.svh"
module boost_pressure_pid_controller_core #(
	parameter int unsigned INTEG_WINDOW_MS = 1000
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [39:0]                     s_tdata,   // pressure_abs[18:0], elapsed_us[38:19]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// duty_tenths[9:0], energised[10], regulating[11], boost_gauge[31:12], limit_reached[32]
	output logic [39:0]                     m_tdata,
	input  logic                            cfg_we,
	input  logic [bppc_pkg::IDX_W-1:0]      cfg_index,
	input  logic [bppc_pkg::CFG_W-1:0]      cfg_wdata
);

	localparam int unsigned WIN_MS    = (INTEG_WINDOW_MS == 0) ? 1 : INTEG_WINDOW_MS;
	localparam int unsigned DIV_D     = 1000 * WIN_MS;
	localparam int unsigned DIV_MAX   = (DIV_D > bppc_pkg::DUTY_SCALE) ? DIV_D :
	                                    bppc_pkg::DUTY_SCALE;
	localparam int unsigned DIVISOR_W = $clog2(DIV_MAX + 1);

	bppc_pkg::cfg_t    cfg_q;
	bppc_pkg::cmd_t    cmd;
	bppc_pkg::status_t status;
	bppc_pkg::res_t    res, out_q;
	logic              out_valid_q, out_free, publish;
	logic [9:0]        v10;

	// duty registers saturate at 999
	assign v10 = (cfg_wdata[9:0] > 10'(bppc_pkg::DUTY_MAX)) ? 10'(bppc_pkg::DUTY_MAX) :
	             cfg_wdata[9:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target    <= 19'd100000;
			cfg_q.energise  <= 19'd50000;
			cfg_q.pid_start <= 19'd75000;
			cfg_q.kp_k      <= 26'd6000000;
			cfg_q.ki        <= 16'd1000;
			cfg_q.kd_k      <= 26'd500000;
			cfg_q.ceiling   <= 10'd950;
			cfg_q.offset_k  <= 27'd50000000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bppc_pkg::REG_TARGET:    cfg_q.target    <= cfg_wdata;
				bppc_pkg::REG_ENERGISE:  cfg_q.energise  <= cfg_wdata;
				bppc_pkg::REG_PID_START: cfg_q.pid_start <= cfg_wdata;
				bppc_pkg::REG_PROP:
					cfg_q.kp_k <= {10'b0, cfg_wdata[15:0]} * 26'(bppc_pkg::GAIN_SCALE);
				bppc_pkg::REG_INTEG:     cfg_q.ki        <= cfg_wdata[15:0];
				bppc_pkg::REG_DERIV:
					cfg_q.kd_k <= {10'b0, cfg_wdata[15:0]} * 26'(bppc_pkg::GAIN_SCALE);
				bppc_pkg::REG_CEILING:   cfg_q.ceiling   <= v10;
				bppc_pkg::REG_OFFSET:
					cfg_q.offset_k <= {17'b0, v10} * 27'(bppc_pkg::DUTY_SCALE);
				default: ;
			endcase
		end
	end

	bppc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s_tvalid),
		.out_free   (out_free),
		.status     (status),
		.item_ready (s_tready),
		.cmd        (cmd)
	);

	bppc_dp #(
		.DIV_D     (DIV_D),
		.DIVISOR_W (DIVISOR_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg_q),
		.pressure_abs (s_tdata[18:0]),
		.elapsed_us   (s_tdata[38:19]),
		.status       (status),
		.res          (res)
	);

	// output register
	assign out_free = !out_valid_q || m_tready;
	assign publish  = (cmd.op == bppc_pkg::OP_PUBLISH) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (publish)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (publish)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_q.limit, out_q.boost, out_q.regulating, out_q.energised,
	                   out_q.duty};

	`ASSERT_IMPL(a_duty_ceiling, clk, arst_n, m_tvalid, m_tdata[9:0] <= cfg_q.ceiling, "duty above ceiling")
	`ASSERT_IMPL(a_off_zero, clk, arst_n, m_tvalid && !m_tdata[10], m_tdata[9:0] == 10'd0 && !m_tdata[11], "de-energised result not zero")
	`ASSERT_IMPL(a_accept_div_idle, clk, arst_n, s_tvalid && s_tready, !status.div_busy, "sample taken while divider busy")

endmodule

@@ sim/bppc_checker.sv @@
// checker for the boost pressure pid controller: watches the sample, result and register
// write channels, predicts each duty result and compares it field by field
// depends on bppc_pkg
`timescale 1ns / 100ps
module bppc_checker #(
	parameter int unsigned INTEG_WINDOW_MS = 1000
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [39:0]                  s_tdata,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [39:0]                  m_tdata,
	input  logic                         cfg_we,
	input  logic [bppc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [bppc_pkg::CFG_W-1:0]   cfg_wdata,
	output int                           pending,
	output int                           errors
);

	localparam longint INT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	// packed from the top bit down, so duty lands in the lowest bits as on m_tdata
	typedef struct packed {
		logic        limit;
		logic [19:0] boost;
		logic        regulating;
		logic        energised;
		logic [9:0]  duty;
	} duty_res_t;

	// register copies
	logic [18:0] target, energise, pid_start;
	logic [15:0] kp, ki, kd;
	logic [9:0]  ceiling, offset;
	// controller state
	logic   solenoid_on, pid_running;
	longint last_err, integ;

	duty_res_t duty_q[$];

	function automatic longint clamp_i64(input logic signed [127:0] v);
		if (v > INT_MAX)
			return INT_MAX;
		if (v < -INT_MAX)
			return -INT_MAX;
		return longint'(v);
	endfunction

	// integrator bleeds off over the window, truncating toward zero
	function automatic longint leak_integ(input longint v, input logic [19:0] dt);
		logic [127:0] m, l, d, mag;
		logic         neg;
		d = (INTEG_WINDOW_MS == 0) ? 128'd1000 : 128'd1000 * INTEG_WINDOW_MS;
		neg = v < 0;
		m = neg ? 128'(-v) : 128'(v);
		l = m * dt / d;
		if (l <= m) begin
			mag = m - l;
		end else begin
			mag = l - m;
			neg = !neg;
		end
		if (mag > 128'(INT_MAX))
			mag = 128'(INT_MAX);
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic duty_res_t control_step(input logic [18:0] pres, input logic [19:0] dt_in);
		duty_res_t r;
		longint boost, e, de;
		logic [127:0] dt, m, ip;
		logic signed [127:0] total, iterm;
		boost = longint'(pres) - bppc_pkg::ATM_PRESSURE;
		dt = dt_in;
		r = '0;
		if (solenoid_on && boost < longint'(energise) - bppc_pkg::HYSTERESIS)
			solenoid_on = 1'b0;
		else if (!solenoid_on && boost > longint'(energise))
			solenoid_on = 1'b1;
		if (solenoid_on) begin
			if (boost < longint'(pid_start)) begin
				r.duty = ceiling;
				pid_running = 1'b0;
			end else begin
				e = boost - longint'(target);
				if (!pid_running) begin
					last_err = 0;
					integ = 0;
					dt = 0;
					pid_running = 1'b1;
				end
				de = e - last_err;
				integ = leak_integ(integ, dt[19:0]);
				integ = clamp_i64(128'(integ) + 128'(e) * $signed({1'b0, dt[19:0]}));
				m = integ < 0 ? 128'(-integ) : 128'(integ);
				ip = m * ki;
				if (ip > 128'(bppc_pkg::ITERM_CAP))
					ip = 128'(bppc_pkg::ITERM_CAP);
				iterm = integ < 0 ? -$signed(ip) : $signed(ip);
				total = 128'(e) * kp * 1000 + 128'(de) * kd * 1000 + iterm
					+ 128'(offset) * 100000;
				if (total < 0)
					r.duty = '0;
				else if (total / 100000 > ceiling)
					r.duty = ceiling;
				else
					r.duty = 10'(total / 100000);
				last_err = e;
				r.regulating = 1'b1;
			end
		end else begin
			pid_running = 1'b0;
		end
		r.energised = solenoid_on;
		r.boost = boost[19:0];
		r.limit = boost >= longint'(target);
		return r;
	endfunction

	function automatic logic [9:0] sat_tenths(input logic [18:0] v);
		return (v[9:0] > 10'd999) ? 10'd999 : v[9:0];
	endfunction

	assign pending = duty_q.size();

	always @(posedge clk or negedge arst_n) begin
		duty_res_t want, got;
		if (!arst_n) begin
			target <= 19'd100000;
			energise <= 19'd50000;
			pid_start <= 19'd75000;
			kp <= 16'd6000;
			ki <= 16'd1000;
			kd <= 16'd500;
			ceiling <= 10'd950;
			offset <= 10'd500;
			solenoid_on = 1'b0;
			pid_running = 1'b0;
			last_err = 0;
			integ = 0;
			duty_q.delete();
			errors <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bppc_pkg::REG_TARGET: target <= cfg_wdata;
					bppc_pkg::REG_ENERGISE: energise <= cfg_wdata;
					bppc_pkg::REG_PID_START: pid_start <= cfg_wdata;
					bppc_pkg::REG_PROP: kp <= cfg_wdata[15:0];
					bppc_pkg::REG_INTEG: ki <= cfg_wdata[15:0];
					bppc_pkg::REG_DERIV: kd <= cfg_wdata[15:0];
					bppc_pkg::REG_CEILING: ceiling <= sat_tenths(cfg_wdata);
					bppc_pkg::REG_OFFSET: offset <= sat_tenths(cfg_wdata);
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				duty_q.push_back(control_step(s_tdata[18:0], s_tdata[38:19]));
			if (m_tvalid && m_tready) begin
				got = m_tdata[32:0];
				if (duty_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected result transfer: %h", m_tdata);
					errors <= errors + 1;
				end else begin
					want = duty_q.pop_front();
					if (got.duty !== want.duty || got.energised !== want.energised
							|| got.regulating !== want.regulating
							|| got.boost !== want.boost || got.limit !== want.limit) begin
						if (errors < 10)
							$display({"mismatch: duty %0d/%0d en %b/%b reg %b/%b ",
								"boost %0d/%0d limit %b/%b (expected/actual)"},
								want.duty, got.duty, want.energised, got.energised,
								want.regulating, got.regulating, $signed(want.boost),
								$signed(got.boost), want.limit, got.limit);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

@@ sim/tb_boost_pressure_pid_controller_core.sv @@
// testbench top for the boost pressure pid controller: drives samples and register writes,
// stalls the result side, and gives the verdict from the checker's error count
// depends on bppc_pkg, bppc_checker and the controller rtl
`timescale 1ns / 100ps
module tb_boost_pressure_pid_controller_core;

	localparam int ATM = 101325;
	localparam int WATCHDOG_LIMIT = 5000;

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, m_tvalid, m_tready;
	logic [39:0] s_tdata, m_tdata;
	logic        cfg_we;
	logic [bppc_pkg::IDX_W-1:0] cfg_index;
	logic [bppc_pkg::CFG_W-1:0] cfg_wdata;
	int pending, errors;
	int idle_cycles = 0;
	logic calm;

	boost_pressure_pid_controller_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	bppc_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.pending(pending), .errors(errors)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic send_sample(input logic [18:0] pres, input logic [19:0] dt);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, dt, pres};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [bppc_pkg::IDX_W-1:0] idx,
			input logic [bppc_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// block has to be quiet before its registers change
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (70) @(negedge clk);
	endtask

	function automatic logic [18:0] pick_boost_reg();
		case ($urandom_range(0, 5))
			0: return 19'd0;
			1: return 19'd400000;
			2: return 19'h7FFFF;
			default: return 19'($urandom_range(0, 150000));
		endcase
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 4))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 8000));
		endcase
	endfunction

	function automatic logic [18:0] pick_tenths();
		case ($urandom_range(0, 4))
			0: return 19'd0;
			1: return 19'd999;
			2: return 19'd1023;
			default: return 19'($urandom_range(0, 999));
		endcase
	endfunction

	// receiver: short random stalls, one long hold-off while samples keep coming
	initial begin
		int cyc;
		cyc = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc == 4000) begin
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin
		int phase, lo;
		calm = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: field extremes and the hysteresis and activation edges at reset values
		send_sample(19'd0, 20'd0);
		send_sample(19'h7FFFF, 20'hFFFFF);
		send_sample(19'(ATM), 20'd1000);
		send_sample(19'(ATM + 50000), 20'd1000);
		send_sample(19'(ATM + 50001), 20'd1000);
		send_sample(19'(ATM + 74999), 20'd1000);
		send_sample(19'(ATM + 75000), 20'd5000);
		send_sample(19'(ATM + 100000), 20'd1000000);
		send_sample(19'(ATM + 120000), 20'hFFFFF);
		send_sample(19'(ATM + 400000), 20'd0);
		send_sample(19'(ATM + 45000), 20'd1000);
		send_sample(19'(ATM + 44999), 20'd1000);
		send_sample(19'(ATM + 80000), 20'd1000);
		drain();
		write_reg(bppc_pkg::REG_PROP, 19'hFFFF);
		write_reg(bppc_pkg::REG_INTEG, 19'hFFFF);
		write_reg(bppc_pkg::REG_DERIV, 19'hFFFF);
		write_reg(bppc_pkg::REG_CEILING, 19'd1023);
		write_reg(bppc_pkg::REG_OFFSET, 19'd999);
		write_reg(bppc_pkg::REG_TARGET, 19'd400000);
		write_reg(bppc_pkg::REG_ENERGISE, 19'd0);
		write_reg(bppc_pkg::REG_PID_START, 19'd0);
		for (int i = 0; i < 6; i++)
			send_sample(19'(ATM + 1 + i * 80000), 20'hFFFFF);
		send_sample(19'h7FFFF, 20'hFFFFF);
		send_sample(19'h7FFFF, 20'hFFFFF);

		// random phases, each under fresh register values
		for (phase = 0; phase < 9; phase++) begin
			drain();
			write_reg(bppc_pkg::REG_TARGET, pick_boost_reg());
			write_reg(bppc_pkg::REG_ENERGISE, pick_boost_reg());
			write_reg(bppc_pkg::REG_PID_START, pick_boost_reg());
			write_reg(bppc_pkg::REG_PROP, pick_gain());
			write_reg(bppc_pkg::REG_INTEG, pick_gain());
			write_reg(bppc_pkg::REG_DERIV, pick_gain());
			write_reg(bppc_pkg::REG_CEILING, pick_tenths());
			write_reg(bppc_pkg::REG_OFFSET, pick_tenths());
			lo = ATM + int'(chk.pid_start);
			for (int i = 0; i < 205; i++) begin
				if (phase == 8 && i == 20)
					calm = 1'b1;
				if ($urandom_range(0, 9) < 7 && lo < 524287)
					send_sample(19'($urandom_range(lo, 524287)),
						20'($urandom_range(0, 1000000)));
				else
					send_sample(19'($urandom_range(0, 524287)), 20'($urandom_range(0, 1048575)));
			end
		end
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
